// ===== hw/rtl/cau_pkg.sv =====
// Shared types, constants and helper functions of the complex arithmetic unit.
// Depends on nothing; every other file of the unit imports it.
package cau_pkg;

	// Number format and derived widths.
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int OP_W      = 3;
	localparam int MAG_W     = 2 * DATA_W;
	localparam int QUO_W     = MAG_W + FRAC_BITS;
	localparam int SQ_STEPS  = MAG_W / 2;

	// Clamp limits as magnitudes.
	localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(1) << (DATA_W - 1);
	localparam logic [MAG_W-1:0] POS_LIM = NEG_LIM - MAG_W'(1);

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 3'd0,
		OP_SUB    = 3'd1,
		OP_MUL    = 3'd2,
		OP_DIV    = 3'd3,
		OP_CONJ   = 3'd4,
		OP_ABS_SQ = 3'd5,
		OP_ABS    = 3'd6
	} op_t;

	// One complex result with its saturation flag.
	typedef struct packed {
		logic [DATA_W-1:0] re;
		logic [DATA_W-1:0] im;
		logic              sat;
	} cres_t;

	// One clamped part.
	typedef struct packed {
		logic [DATA_W-1:0] val;
		logic              sat;
	} clamp_t;

	// Output of the product front end.
	typedef struct packed {
		op_t              op;
		logic             use_simple;
		cres_t            simple;
		logic             re_neg;
		logic [MAG_W-1:0] re_mag;
		logic             im_neg;
		logic [MAG_W-1:0] im_mag;
		logic [MAG_W-1:0] den;
	} front_t;

	// State carried through the divide and square root stages.
	typedef struct packed {
		front_t           f;
		logic [MAG_W-1:0] rem_re;
		logic [MAG_W-1:0] rem_im;
		logic [QUO_W-1:0] quo_re;
		logic [QUO_W-1:0] quo_im;
		logic [MAG_W-1:0] sq_rem;
		logic [MAG_W-1:0] sq_root;
	} iter_t;

	// Sign and magnitude to a clamped signed word; big marks bits above the magnitude.
	function automatic clamp_t clamp_sm(input logic neg, input logic big,
			input logic [MAG_W-1:0] mag);
		clamp_t r;
		r.sat = 1'b0;
		r.val = mag[DATA_W-1:0];
		if (!neg) begin
			if (big || (mag > POS_LIM)) begin
				r.sat = 1'b1;
				r.val = POS_LIM[DATA_W-1:0];
			end
		end else begin
			if (big || (mag > NEG_LIM)) begin
				r.sat = 1'b1;
				r.val = NEG_LIM[DATA_W-1:0];
			end else begin
				r.val = -mag[DATA_W-1:0];
			end
		end
		return r;
	endfunction

	// A sum one bit wider than a word, clamped to the signed word range.
	function automatic clamp_t clamp_wide(input logic [DATA_W:0] v);
		clamp_t r;
		r.sat = 1'b0;
		r.val = v[DATA_W-1:0];
		if (v[DATA_W] != v[DATA_W-1]) begin
			r.sat = 1'b1;
			r.val = v[DATA_W] ? NEG_LIM[DATA_W-1:0] : POS_LIM[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/cau_front.sv =====
// Front end of the complex arithmetic unit: input register, products, sums, sign split.
// Depends on cau_pkg.
module cau_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  cau_pkg::op_t       in_op,
	input  logic [31:0]        in_a_re,
	input  logic [31:0]        in_a_im,
	input  logic [31:0]        in_b_re,
	input  logic [31:0]        in_b_im,
	output logic               out_valid,
	output cau_pkg::front_t    out_f
);
	import cau_pkg::*;

	logic                     v_s1, v_s2, v_s3, v_s4;
	op_t                      op_s1, op_s2, op_s3;
	logic signed [DATA_W-1:0] a_re_s1, a_im_s1, b_re_s1, b_im_s1;
	logic                     use_s2, use_s3;
	cres_t                    simple_s2, simple_s3;
	logic signed [MAG_W-1:0]  m0_s2, m1_s2, m2_s2, m3_s2, m4_s2, m5_s2;
	logic signed [MAG_W:0]    re_sum_s3, im_sum_s3;
	logic [MAG_W-1:0]         den_s3;
	front_t                   f_s4;

	logic                     abs_op, b_zero;
	logic signed [DATA_W-1:0] m0_rhs, m1_rhs;
	cres_t                    simple_c;
	clamp_t                   cl_re, cl_im;
	logic signed [MAG_W:0]    re_sum_c, im_sum_c;

	// Valid bits travel with the data; the whole line moves on enable.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: register the request.
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= in_op;
			a_re_s1 <= in_a_re;
			a_im_s1 <= in_a_im;
			b_re_s1 <= in_b_re;
			b_im_s1 <= in_b_im;
		end
	end

	// Stage 2 logic: results that need no product, and multiplier operand selection.
	always_comb begin
		abs_op   = (op_s1 == OP_ABS_SQ) || (op_s1 == OP_ABS);
		b_zero   = (b_re_s1 == '0) && (b_im_s1 == '0);
		m0_rhs   = abs_op ? a_re_s1 : b_re_s1;
		m1_rhs   = abs_op ? a_im_s1 : b_im_s1;
		simple_c = '0;
		cl_re    = '0;
		cl_im    = '0;
		case (op_s1)
			OP_ADD: begin
				cl_re = clamp_wide((DATA_W+1)'(a_re_s1) + (DATA_W+1)'(b_re_s1));
				cl_im = clamp_wide((DATA_W+1)'(a_im_s1) + (DATA_W+1)'(b_im_s1));
			end
			OP_SUB: begin
				cl_re = clamp_wide((DATA_W+1)'(a_re_s1) - (DATA_W+1)'(b_re_s1));
				cl_im = clamp_wide((DATA_W+1)'(a_im_s1) - (DATA_W+1)'(b_im_s1));
			end
			OP_CONJ: begin
				cl_re = '{val: a_re_s1, sat: 1'b0};
				cl_im = clamp_wide(-(DATA_W+1)'(a_im_s1));
			end
			OP_DIV: begin
				// Divide by zero hands a back untouched.
				cl_re = '{val: a_re_s1, sat: 1'b0};
				cl_im = '{val: a_im_s1, sat: 1'b0};
			end
			default: begin
				cl_re = '0;
				cl_im = '0;
			end
		endcase
		simple_c.re  = cl_re.val;
		simple_c.im  = cl_im.val;
		simple_c.sat = cl_re.sat | cl_im.sat;
	end

	// Stage 2: six signed products.
	always_ff @(posedge clk) begin
		if (en) begin
			op_s2     <= op_s1;
			simple_s2 <= simple_c;
			use_s2    <= !((op_s1 == OP_MUL) || abs_op || ((op_s1 == OP_DIV) && !b_zero));
			m0_s2     <= MAG_W'(a_re_s1) * MAG_W'(m0_rhs);
			m1_s2     <= MAG_W'(a_im_s1) * MAG_W'(m1_rhs);
			m2_s2     <= MAG_W'(a_re_s1) * MAG_W'(b_im_s1);
			m3_s2     <= MAG_W'(a_im_s1) * MAG_W'(b_re_s1);
			m4_s2     <= MAG_W'(b_re_s1) * MAG_W'(b_re_s1);
			m5_s2     <= MAG_W'(b_im_s1) * MAG_W'(b_im_s1);
		end
	end

	// Stage 3 logic: the product sums each operation needs.
	always_comb begin
		re_sum_c = '0;
		im_sum_c = '0;
		case (op_s2)
			OP_MUL: begin
				re_sum_c = (MAG_W+1)'(m0_s2) - (MAG_W+1)'(m1_s2);
				im_sum_c = (MAG_W+1)'(m2_s2) + (MAG_W+1)'(m3_s2);
			end
			OP_DIV: begin
				re_sum_c = (MAG_W+1)'(m0_s2) + (MAG_W+1)'(m1_s2);
				im_sum_c = (MAG_W+1)'(m3_s2) - (MAG_W+1)'(m2_s2);
			end
			OP_ABS_SQ, OP_ABS: begin
				re_sum_c = (MAG_W+1)'(m0_s2) + (MAG_W+1)'(m1_s2);
			end
			default: begin
				re_sum_c = '0;
				im_sum_c = '0;
			end
		endcase
	end

	// Stage 3: sums and the squared magnitude of b.
	always_ff @(posedge clk) begin
		if (en) begin
			op_s3     <= op_s2;
			use_s3    <= use_s2;
			simple_s3 <= simple_s2;
			re_sum_s3 <= re_sum_c;
			im_sum_s3 <= im_sum_c;
			den_s3    <= m4_s2[MAG_W-1:0] + m5_s2[MAG_W-1:0];
		end
	end

	// Stage 4: split the sums into sign and magnitude.
	always_ff @(posedge clk) begin
		if (en) begin
			f_s4.op         <= op_s3;
			f_s4.use_simple <= use_s3;
			f_s4.simple     <= simple_s3;
			f_s4.re_neg     <= re_sum_s3[MAG_W];
			f_s4.re_mag     <= re_sum_s3[MAG_W] ? MAG_W'(-re_sum_s3) : re_sum_s3[MAG_W-1:0];
			f_s4.im_neg     <= im_sum_s3[MAG_W];
			f_s4.im_mag     <= im_sum_s3[MAG_W] ? MAG_W'(-im_sum_s3) : im_sum_s3[MAG_W-1:0];
			f_s4.den        <= den_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_f     = f_s4;

endmodule

// ===== hw/rtl/cau_iter.sv =====
// Pipelined restoring dividers for both result parts and the integer square root,
// one quotient bit and at most one root step per stage. Depends on cau_pkg.
module cau_iter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  cau_pkg::front_t   in_f,
	output logic              out_valid,
	output cau_pkg::iter_t    out_it
);
	import cau_pkg::*;

	iter_t step_s [QUO_W];
	logic  vld_s  [QUO_W];
	iter_t init;

	// Divider state and the partial root start from zero; the root remainder starts from the real magnitude.
	always_comb begin
		init         = '0;
		init.f       = in_f;
		init.sq_rem  = in_f.re_mag;
	end

	genvar k;
	for (k = 0; k < QUO_W; k++) begin : g_step
		localparam int P = QUO_W - 1 - k;
		iter_t            cur;
		iter_t            nxt;
		logic             vin;
		logic             bit_re, bit_im;
		logic [MAG_W:0]   trial_re, trial_im;
		logic             ge_re, ge_im;

		if (k == 0) begin : g_first
			assign cur = init;
			assign vin = in_valid;
		end else begin : g_next
			assign cur = step_s[k-1];
			assign vin = vld_s[k-1];
		end

		// Dividend bit for this stage: the magnitude followed by zero fraction bits.
		if (P >= FRAC_BITS) begin : g_bit
			assign bit_re = cur.f.re_mag[P-FRAC_BITS];
			assign bit_im = cur.f.im_mag[P-FRAC_BITS];
		end else begin : g_zero
			assign bit_re = 1'b0;
			assign bit_im = 1'b0;
		end

		// One restoring division step for each part.
		always_comb begin
			trial_re = {cur.rem_re, bit_re};
			trial_im = {cur.rem_im, bit_im};
			ge_re    = trial_re >= {1'b0, cur.f.den};
			ge_im    = trial_im >= {1'b0, cur.f.den};
		end

		if (k < SQ_STEPS) begin : g_sqrt
			localparam logic [MAG_W-1:0] SQ_BIT = MAG_W'(1) << (MAG_W - 2 - 2 * k);
			logic [MAG_W-1:0] sq_try;

			// One digit of the square root.
			always_comb begin
				sq_try = cur.sq_root + SQ_BIT;
				nxt    = cur;
				nxt.rem_re = ge_re ? MAG_W'(trial_re - {1'b0, cur.f.den}) : trial_re[MAG_W-1:0];
				nxt.rem_im = ge_im ? MAG_W'(trial_im - {1'b0, cur.f.den}) : trial_im[MAG_W-1:0];
				nxt.quo_re = {cur.quo_re[QUO_W-2:0], ge_re};
				nxt.quo_im = {cur.quo_im[QUO_W-2:0], ge_im};
				if (cur.sq_rem >= sq_try) begin
					nxt.sq_rem  = cur.sq_rem - sq_try;
					nxt.sq_root = (cur.sq_root >> 1) + SQ_BIT;
				end else begin
					nxt.sq_root = cur.sq_root >> 1;
				end
			end
		end else begin : g_div_only
			// Root is finished; only the division goes on.
			always_comb begin
				nxt        = cur;
				nxt.rem_re = ge_re ? MAG_W'(trial_re - {1'b0, cur.f.den}) : trial_re[MAG_W-1:0];
				nxt.rem_im = ge_im ? MAG_W'(trial_im - {1'b0, cur.f.den}) : trial_im[MAG_W-1:0];
				nxt.quo_re = {cur.quo_re[QUO_W-2:0], ge_re};
				nxt.quo_im = {cur.quo_im[QUO_W-2:0], ge_im};
			end
		end

		// Stage register and its valid bit.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				step_s[k] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[QUO_W-1];
	assign out_it    = step_s[QUO_W-1];

endmodule

// ===== hw/rtl/complex_arithmetic_unit_top.sv =====
// Complex arithmetic unit on signed Q16.16 operands, stream in and stream out.
// 4 front stages, 80 divider stages of one quotient bit each, then one output register.
// Throughput: one request per cycle; a stall holds the whole pipeline in place.
// Reset clears every valid bit, the output and skid flags included; data registers keep
// whatever they hold. Depends on cau_pkg, cau_front and cau_iter.
module complex_arithmetic_unit_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // a_re, a_im, b_re, b_im
	input  logic [2:0]   s_tuser,   // op
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // res_re, res_im
	output logic [0:0]   m_tuser    // saturated
);
	import cau_pkg::*;

	logic     en;
	logic     f_valid, it_valid;
	front_t   f_out;
	iter_t    it_out;
	cres_t    res_c;
	cres_t    out_q, skid_q;
	logic     out_valid_q, skid_valid_q;
	logic     push, take;

	logic [MAG_W-1:0] floor_re, floor_im, fmask;
	logic             big_re, big_im;
	clamp_t           cr, ci;

	// The pipeline moves whenever the skid stage is free.
	assign en       = !skid_valid_q;
	assign s_tready = en;

	cau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.in_op     (op_t'(s_tuser)),
		.in_a_re   (s_tdata[31:0]),
		.in_a_im   (s_tdata[63:32]),
		.in_b_re   (s_tdata[95:64]),
		.in_b_im   (s_tdata[127:96]),
		.out_valid (f_valid),
		.out_f     (f_out)
	);

	cau_iter u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.in_f      (f_out),
		.out_valid (it_valid),
		.out_it    (it_out)
	);

	// Final scaling, clamping and selection of the result.
	always_comb begin
		fmask    = (MAG_W'(1) << FRAC_BITS) - MAG_W'(1);
		floor_re = (it_out.f.re_mag >> FRAC_BITS)
			+ MAG_W'(it_out.f.re_neg && ((it_out.f.re_mag & fmask) != '0));
		floor_im = (it_out.f.im_mag >> FRAC_BITS)
			+ MAG_W'(it_out.f.im_neg && ((it_out.f.im_mag & fmask) != '0));
		big_re   = (it_out.quo_re >> MAG_W) != '0;
		big_im   = (it_out.quo_im >> MAG_W) != '0;
		cr       = '0;
		ci       = '0;
		case (it_out.f.op)
			OP_MUL: begin
				cr = clamp_sm(it_out.f.re_neg, 1'b0, floor_re);
				ci = clamp_sm(it_out.f.im_neg, 1'b0, floor_im);
			end
			OP_DIV: begin
				cr = clamp_sm(it_out.f.re_neg, big_re, it_out.quo_re[MAG_W-1:0]);
				ci = clamp_sm(it_out.f.im_neg, big_im, it_out.quo_im[MAG_W-1:0]);
			end
			OP_ABS_SQ: begin
				cr = clamp_sm(1'b0, 1'b0, floor_re);
			end
			OP_ABS: begin
				cr = clamp_sm(1'b0, 1'b0, it_out.sq_root);
			end
			default: begin
				cr = '0;
				ci = '0;
			end
		endcase
		if (it_out.f.use_simple) begin
			res_c = it_out.f.simple;
		end else begin
			res_c.re  = cr.val;
			res_c.im  = ci.val;
			res_c.sat = cr.sat | ci.sat;
		end
	end

	// Output register with a skid stage behind it.
	assign push = en && it_valid;
	assign take = out_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else if (!push) begin
					out_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (!out_valid_q) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res_c;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_q <= res_c;
			end else begin
				skid_q <= res_c;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.im, out_q.re};
	assign m_tuser  = out_q.sat;

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for complex_arithmetic_unit_top: random and directed complex requests,
// results predicted in the bench and compared in order. Depends on cau_pkg and the RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cau_pkg::*;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] ar, ai, br, bi;
	} creq_t;

	typedef struct {
		logic [31:0] re, im;
		logic        sat;
	} cexp_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic [0:0]   m_tuser;

	creq_t pending_reqs[$];
	cexp_t expected_results[$];
	int    errors = 0;
	bit    stim_done = 0;
	int    idle_cycles = 0;
	int    send_gap = 0;
	int    recv_gap = 0;

	complex_arithmetic_unit_top dut (.*);

	always #5 clk = ~clk;

	// Clamp a wide signed value to the 32-bit word.
	function automatic logic [31:0] sat_word(input logic signed [130:0] v, inout logic sat);
		if (v > 131'sd2147483647) begin
			sat = 1'b1;
			return 32'h7fffffff;
		end
		if (v < -131'sd2147483648) begin
			sat = 1'b1;
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	// Truncating quotient of (n << FRAC_BITS) by a positive d.
	function automatic logic signed [130:0] div_trunc(input logic signed [130:0] n,
			input logic signed [130:0] d);
		logic signed [130:0] m;
		logic signed [130:0] q;
		m = (n < 0) ? -n : n;
		q = (m <<< FRAC_BITS) / d;
		return (n < 0) ? -q : q;
	endfunction

	function automatic logic [63:0] root_floor(input logic [63:0] s);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'h4000000000000000;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Predict the result of one complex request.
	function automatic cexp_t complex_result(input creq_t q);
		cexp_t e;
		logic signed [130:0] ar, ai, br, bi, t, d;
		logic [63:0] m;
		ar = $signed(q.ar); ai = $signed(q.ai);
		br = $signed(q.br); bi = $signed(q.bi);
		e.re = '0; e.im = '0; e.sat = 1'b0;
		case (q.op)
			OP_ADD: begin
				e.re = sat_word(ar + br, e.sat);
				e.im = sat_word(ai + bi, e.sat);
			end
			OP_SUB: begin
				e.re = sat_word(ar - br, e.sat);
				e.im = sat_word(ai - bi, e.sat);
			end
			OP_MUL: begin
				t = ar * br - ai * bi;
				e.re = sat_word(t >>> FRAC_BITS, e.sat);
				t = ar * bi + ai * br;
				e.im = sat_word(t >>> FRAC_BITS, e.sat);
			end
			OP_DIV: begin
				d = br * br + bi * bi;
				if (d == 0) begin
					e.re = q.ar;
					e.im = q.ai;
				end else begin
					e.re = sat_word(div_trunc(ar * br + ai * bi, d), e.sat);
					e.im = sat_word(div_trunc(ai * br - ar * bi, d), e.sat);
				end
			end
			OP_CONJ: begin
				e.re = q.ar;
				e.im = sat_word(-ai, e.sat);
			end
			OP_ABS_SQ: begin
				t = ar * ar + ai * ai;
				e.re = sat_word(t >>> FRAC_BITS, e.sat);
			end
			OP_ABS: begin
				t = ar * ar + ai * ai;
				m = t[63:0];
				e.re = sat_word({67'd0, root_floor(m)}, e.sat);
			end
			default: ;
		endcase
		return e;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'h0;
			3: return 32'(signed'($urandom_range(0, 2000)) - 1000);
			4: return 32'($urandom_range(0, 32'h3ffff)) - 32'h20000;
			5: return 32'hffffffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic int rand_gap();
		if ($urandom_range(0, 3) != 0) return 0;
		if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Stimulus: directed corners, then random requests.
	initial begin
		logic [31:0] ext[4];
		creq_t q;
		ext = '{32'h80000000, 32'h7fffffff, 32'h0, 32'h00010000};
		for (int o = 0; o < 8; o++) begin
			q.op = 3'(o);
			q.ar = ext[0]; q.ai = ext[0]; q.br = ext[1]; q.bi = ext[0];
			pending_reqs.push_back(q);
			q.ar = ext[1]; q.ai = ext[1]; q.br = ext[2]; q.bi = ext[2];
			pending_reqs.push_back(q);
			q.ar = ext[3]; q.ai = 32'hffffffff; q.br = ext[3]; q.bi = ext[2];
			pending_reqs.push_back(q);
		end
		for (int i = 0; i < 650; i++) begin
			q.op = ($urandom_range(0, 19) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
			q.ar = rand_word(); q.ai = rand_word();
			q.br = rand_word(); q.bi = rand_word();
			if (q.op == OP_DIV && $urandom_range(0, 9) == 0) begin
				q.br = '0;
				q.bi = '0;
			end
			pending_reqs.push_back(q);
		end
		stim_done = 1;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Request driver.
	always @(posedge clk) begin
		creq_t q;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				q.op = s_tuser;
				{q.bi, q.br, q.ai, q.ar} = s_tdata;
				expected_results.push_back(complex_result(q));
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					q = pending_reqs.pop_front();
					s_tdata <= {q.bi, q.br, q.ai, q.ar};
					s_tuser <= q.op;
					s_tvalid <= 1'b1;
					send_gap <= rand_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and back pressure.
	always @(posedge clk) begin
		cexp_t e;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %h sat %b", $time, m_tdata, m_tuser);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (m_tdata[31:0] !== e.re)
						$display("%0t: res_re expected %h actual %h", $time, e.re,
							m_tdata[31:0]);
					if (m_tdata[63:32] !== e.im)
						$display("%0t: res_im expected %h actual %h", $time, e.im,
							m_tdata[63:32]);
					if (m_tuser[0] !== e.sat)
						$display("%0t: saturated expected %b actual %b", $time, e.sat,
							m_tuser[0]);
					if (m_tdata[31:0] !== e.re || m_tdata[63:32] !== e.im ||
							m_tuser[0] !== e.sat)
						errors++;
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				recv_gap <= rand_gap();
			end
		end
	end

	// Watchdog on cycles without any accepted request or taken result.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		wait (stim_done && arst_n);
		wait (pending_reqs.size() == 0 && !s_tvalid);
		wait (expected_results.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
